@@ src/tss_pkg.sv @@
`default_nettype none
package tss_pkg;

    localparam int NUM_TASKS   = 8;
    localparam int QUEUE_DEPTH = 8;
    localparam int NUM_SEMS    = 4;

    localparam int TASK_W     = $clog2(NUM_TASKS);
    localparam int SEM_W      = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
    localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int SCNT_W     = $clog2(NUM_TASKS + 1);
    localparam int WAIT_DEPTH = NUM_SEMS * QUEUE_DEPTH;
    localparam int WADDR_W    = $clog2(WAIT_DEPTH);

    localparam int SLEEP_W  = 16;
    localparam int RATE_W   = 10;
    localparam int SEMI_W   = 7;
    localparam int COUNT_W  = 8;
    localparam int CFG_W    = 10;

    // ms / 1000 == ((ms >> 3) * 8389) >> 20, exact over 16 bits
    localparam int MS_SHR     = 3;
    localparam int DIV_K      = 8389;
    localparam int DIV_PROD_W = 27;
    localparam int DIV_SHIFT  = 20;
    localparam int QUOT_W     = 7;
    localparam int TICKS_W    = QUOT_W + RATE_W;
    localparam logic [SLEEP_W-1:0] SLEEP_MAX = '1;

    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_SLEEP = 3'd1;
    localparam logic [2:0] OP_P     = 3'd2;
    localparam logic [2:0] OP_V     = 3'd3;
    localparam logic [2:0] OP_WAKE  = 3'd4;

    localparam logic CFG_TICK_RATE = 1'b0;
    localparam logic CFG_SEM_INIT  = 1'b1;

    localparam logic [RATE_W-1:0] TICK_RATE_RST = RATE_W'(100);
    localparam logic [SEMI_W-1:0] SEM_INIT_RST  = SEMI_W'(1);

    typedef logic [TASK_W-1:0] task_idx_t;
    typedef logic [QPTR_W-1:0] qptr_t;

    function automatic task_idx_t next_task(input task_idx_t t);
        return (int'(t) == NUM_TASKS - 1) ? '0 : task_idx_t'(t + 1'b1);
    endfunction

    function automatic qptr_t next_qptr(input qptr_t p);
        return (int'(p) == QUEUE_DEPTH - 1) ? '0 : qptr_t'(p + 1'b1);
    endfunction

endpackage
`default_nettype wire

@@ src/tss_ram.sv @@
`default_nettype none
module tss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

@@ src/task_scheduler_with_semaphores.sv @@
// Round-robin task scheduler with counting semaphores.
// Input channel s_*: one operation per transfer (tick, sleep, P, V, wakeup).
// Result channel m_*: exactly one result per operation, in order.
// Config port: cfg_we with cfg_addr 0 writes tick_rate, cfg_addr 1 writes
// sem_initial, which reloads every semaphore and empties every wait queue.
// Tick, sleep and a blocking P end with a scheduling pass; a V that releases a
// waiting task first reads it from its semaphore's wait queue.
// Scheduling walks the sleep counter memory one task per cycle through its
// single read port, decrementing and testing each entry in round-robin
// order; sleep adds a two-stage divide and scale before that walk.
// One operation is in flight at a time; s_ready is high once the previous
// result sits in the output register, so the next input can be taken while
// that result waits. A stalled m_ready holds the result and the block
// stops before loading the following result.
// Reset: all tasks awake and unblocked, task 0 running, tick_rate 100,
// every semaphore at 1 with an empty queue. No clearing pass is needed.
`default_nettype none
module task_scheduler_with_semaphores (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_we,
    input  wire logic                       cfg_addr,
    input  wire logic [tss_pkg::CFG_W-1:0]  cfg_wdata,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [2:0]                 s_operation,
    input  wire logic [15:0]                s_sleep_ms,
    input  wire logic [1:0]                 s_sem_id,
    input  wire logic [2:0]                 s_task_id,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [2:0]                      m_current_task,
    output logic                            m_no_ready,
    output logic                            m_woken_valid,
    output logic [2:0]                      m_woken_task,
    output logic signed [7:0]               m_sem_count,
    output logic                            m_queue_overflow
);
    import tss_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_SCAN = 3'd4;
    localparam logic [2:0] ST_VRD  = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    logic [2:0] state_reg, state_next;

    logic [RATE_W-1:0] tick_rate_reg, tick_rate_next;
    logic [SEMI_W-1:0] sem_init_reg, sem_init_next;

    logic [2:0]  op_reg, op_next;
    logic [15:0] ms_reg, ms_next;
    logic [1:0]  sid_reg, sid_next;
    logic [2:0]  tid_reg, tid_next;

    task_idx_t            running_reg, running_next;
    logic [NUM_TASKS-1:0] blocked_reg, blocked_next;
    logic [NUM_TASKS-1:0] sleep_vld_reg, sleep_vld_next;

    logic signed [COUNT_W-1:0] sem_value_reg [NUM_SEMS];
    logic signed [COUNT_W-1:0] sem_value_next [NUM_SEMS];
    qptr_t                     enq_ptr_reg [NUM_SEMS];
    qptr_t                     enq_ptr_next [NUM_SEMS];
    qptr_t                     deq_ptr_reg [NUM_SEMS];
    qptr_t                     deq_ptr_next [NUM_SEMS];
    logic [QCNT_W-1:0]         wait_cnt_reg [NUM_SEMS];
    logic [QCNT_W-1:0]         wait_cnt_next [NUM_SEMS];

    logic [DIV_PROD_W-1:0] div_prod_reg, div_prod_next;

    task_idx_t         scan_idx_reg, scan_idx_next;
    logic [SCNT_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic              pipe_vld_reg, pipe_vld_next;
    task_idx_t         pipe_idx_reg, pipe_idx_next;
    logic              found_reg, found_next;
    task_idx_t         found_idx_reg, found_idx_next;

    logic                      res_no_ready_reg, res_no_ready_next;
    logic                      res_woken_vld_reg, res_woken_vld_next;
    logic [2:0]                res_woken_task_reg, res_woken_task_next;
    logic signed [COUNT_W-1:0] res_count_reg, res_count_next;
    logic                      res_ovf_reg, res_ovf_next;

    logic                      m_valid_reg, m_valid_next;
    logic [2:0]                m_cur_reg, m_cur_next;
    logic                      m_no_ready_reg, m_no_ready_next;
    logic                      m_woken_vld_reg, m_woken_vld_next;
    logic [2:0]                m_woken_task_reg, m_woken_task_next;
    logic signed [COUNT_W-1:0] m_count_reg, m_count_next;
    logic                      m_ovf_reg, m_ovf_next;

    logic               sram_we, sram_re;
    task_idx_t          sram_waddr, sram_raddr;
    logic [SLEEP_W-1:0] sram_wdata, sram_rdata;
    logic               wram_we, wram_re;
    logic [WADDR_W-1:0] wram_waddr, wram_raddr;
    task_idx_t          wram_rdata;

    logic [SEM_W-1:0]          sem_idx;
    logic                      sid_ok, tid_ok;
    logic signed [COUNT_W-1:0] sem_cur, sem_dec, sem_inc;
    logic [SLEEP_W-1:0]        sleep_cur, sleep_dec;
    logic [TICKS_W-1:0]        ticks;
    logic                      hit, scan_start;

    tss_ram #(.WIDTH(SLEEP_W), .DEPTH(NUM_TASKS)) u_sleep_ram (
        .aclk  (aclk),
        .we    (sram_we),
        .waddr (sram_waddr),
        .wdata (sram_wdata),
        .re    (sram_re),
        .raddr (sram_raddr),
        .rdata (sram_rdata)
    );

    tss_ram #(.WIDTH(TASK_W), .DEPTH(WAIT_DEPTH)) u_wait_ram (
        .aclk  (aclk),
        .we    (wram_we),
        .waddr (wram_waddr),
        .wdata (running_reg),
        .re    (wram_re),
        .raddr (wram_raddr),
        .rdata (wram_rdata)
    );

    assign s_ready = (state_reg == ST_IDLE);

    assign sem_idx = SEM_W'(sid_reg);
    assign sid_ok  = int'(sid_reg) < NUM_SEMS;
    assign tid_ok  = int'(tid_reg) < NUM_TASKS;
    assign sem_cur = sem_value_reg[sem_idx];
    assign sem_dec = (sem_cur == -8'sd128) ? sem_cur : sem_cur - 8'sd1;
    assign sem_inc = (sem_cur == 8'sd127) ? sem_cur : sem_cur + 8'sd1;

    // invalid entries read as zero
    assign sleep_cur = sleep_vld_reg[pipe_idx_reg] ? sram_rdata : '0;
    assign sleep_dec = (sleep_cur != '0) ? sleep_cur - 1'b1 : '0;
    assign hit       = pipe_vld_reg && (sleep_dec == '0) && !blocked_reg[pipe_idx_reg];

    assign ticks = TICKS_W'(div_prod_reg[DIV_SHIFT +: QUOT_W]) * TICKS_W'(tick_rate_reg);

    always_comb begin
        state_next          = state_reg;
        tick_rate_next      = tick_rate_reg;
        sem_init_next       = sem_init_reg;
        op_next             = op_reg;
        ms_next             = ms_reg;
        sid_next            = sid_reg;
        tid_next            = tid_reg;
        running_next        = running_reg;
        blocked_next        = blocked_reg;
        sleep_vld_next      = sleep_vld_reg;
        sem_value_next      = sem_value_reg;
        enq_ptr_next        = enq_ptr_reg;
        deq_ptr_next        = deq_ptr_reg;
        wait_cnt_next       = wait_cnt_reg;
        div_prod_next       = div_prod_reg;
        scan_idx_next       = scan_idx_reg;
        scan_cnt_next       = scan_cnt_reg;
        pipe_vld_next       = 1'b0;
        pipe_idx_next       = scan_idx_reg;
        found_next          = found_reg;
        found_idx_next      = found_idx_reg;
        res_no_ready_next   = res_no_ready_reg;
        res_woken_vld_next  = res_woken_vld_reg;
        res_woken_task_next = res_woken_task_reg;
        res_count_next      = res_count_reg;
        res_ovf_next        = res_ovf_reg;
        m_valid_next        = m_valid_reg && !m_ready;
        m_cur_next          = m_cur_reg;
        m_no_ready_next     = m_no_ready_reg;
        m_woken_vld_next    = m_woken_vld_reg;
        m_woken_task_next   = m_woken_task_reg;
        m_count_next        = m_count_reg;
        m_ovf_next          = m_ovf_reg;
        sram_we             = 1'b0;
        sram_waddr          = pipe_idx_reg;
        sram_wdata          = sleep_dec;
        sram_re             = 1'b0;
        sram_raddr          = scan_idx_reg;
        wram_we             = 1'b0;
        wram_waddr          = WADDR_W'(int'(sem_idx) * QUEUE_DEPTH
                                       + int'(enq_ptr_reg[sem_idx]));
        wram_re             = 1'b0;
        wram_raddr          = WADDR_W'(int'(sem_idx) * QUEUE_DEPTH
                                       + int'(deq_ptr_reg[sem_idx]));
        scan_start          = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next             = s_operation;
                    ms_next             = s_sleep_ms;
                    sid_next            = s_sem_id;
                    tid_next            = s_task_id;
                    res_no_ready_next   = 1'b0;
                    res_woken_vld_next  = 1'b0;
                    res_woken_task_next = '0;
                    res_count_next      = '0;
                    res_ovf_next        = 1'b0;
                    state_next          = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_DONE;
                case (op_reg)
                    OP_TICK: begin
                        scan_start = 1'b1;
                    end
                    OP_SLEEP: begin
                        div_prod_next = DIV_PROD_W'(ms_reg[15:MS_SHR]) * DIV_PROD_W'(DIV_K);
                        state_next    = ST_DIV;
                    end
                    OP_P: begin
                        if (sid_ok) begin
                            if (sem_dec[COUNT_W-1]
                                    && int'(wait_cnt_reg[sem_idx]) >= QUEUE_DEPTH) begin
                                res_ovf_next   = 1'b1;
                                res_count_next = sem_cur;
                            end else begin
                                sem_value_next[sem_idx] = sem_dec;
                                res_count_next          = sem_dec;
                                if (sem_dec[COUNT_W-1]) begin
                                    wram_we                   = 1'b1;
                                    enq_ptr_next[sem_idx]     = next_qptr(enq_ptr_reg[sem_idx]);
                                    wait_cnt_next[sem_idx]    = wait_cnt_reg[sem_idx] + 1'b1;
                                    blocked_next[running_reg] = 1'b1;
                                    scan_start                = 1'b1;
                                end
                            end
                        end
                    end
                    OP_V: begin
                        if (sid_ok) begin
                            sem_value_next[sem_idx] = sem_inc;
                            res_count_next          = sem_inc;
                            if ((sem_inc[COUNT_W-1] || sem_inc == '0)
                                    && wait_cnt_reg[sem_idx] != '0) begin
                                wram_re                = 1'b1;
                                deq_ptr_next[sem_idx]  = next_qptr(deq_ptr_reg[sem_idx]);
                                wait_cnt_next[sem_idx] = wait_cnt_reg[sem_idx] - 1'b1;
                                state_next             = ST_VRD;
                            end
                        end
                    end
                    OP_WAKE: begin
                        if (tid_ok) begin
                            blocked_next[TASK_W'(tid_reg)] = 1'b0;
                        end
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_DIV: begin
                state_next = ST_MUL;
            end
            ST_MUL: begin
                sram_we                     = 1'b1;
                sram_waddr                  = running_reg;
                sram_wdata                  = (ticks > TICKS_W'(SLEEP_MAX)) ? SLEEP_MAX
                                                                            : SLEEP_W'(ticks);
                sleep_vld_next[running_reg] = 1'b1;
                scan_start                  = 1'b1;
            end
            ST_SCAN: begin
                if (int'(scan_cnt_reg) < NUM_TASKS) begin
                    sram_re       = 1'b1;
                    pipe_vld_next = 1'b1;
                    scan_idx_next = next_task(scan_idx_reg);
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
                if (pipe_vld_reg) begin
                    sram_we                      = 1'b1;
                    sleep_vld_next[pipe_idx_reg] = 1'b1;
                    if (hit && !found_reg) begin
                        found_next     = 1'b1;
                        found_idx_next = pipe_idx_reg;
                    end
                    if (int'(scan_cnt_reg) == NUM_TASKS) begin
                        if (found_next) begin
                            running_next = found_idx_next;
                        end
                        res_no_ready_next = !found_next;
                        state_next        = ST_DONE;
                    end
                end
            end
            ST_VRD: begin
                blocked_next[wram_rdata] = 1'b0;
                res_woken_vld_next       = 1'b1;
                res_woken_task_next      = 3'(wram_rdata);
                state_next               = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next      = 1'b1;
                    m_cur_next        = 3'(running_reg);
                    m_no_ready_next   = res_no_ready_reg;
                    m_woken_vld_next  = res_woken_vld_reg;
                    m_woken_task_next = res_woken_task_reg;
                    m_count_next      = res_count_reg;
                    m_ovf_next        = res_ovf_reg;
                    state_next        = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (scan_start) begin
            scan_idx_next = next_task(running_reg);
            scan_cnt_next = '0;
            found_next    = 1'b0;
            state_next    = ST_SCAN;
        end

        if (cfg_we) begin
            unique case (cfg_addr)
                CFG_TICK_RATE: begin
                    tick_rate_next = cfg_wdata[RATE_W-1:0];
                end
                CFG_SEM_INIT: begin
                    sem_init_next = cfg_wdata[SEMI_W-1:0];
                    for (int s = 0; s < NUM_SEMS; s++) begin
                        sem_value_next[s] = COUNT_W'(cfg_wdata[SEMI_W-1:0]);
                        enq_ptr_next[s]   = '0;
                        deq_ptr_next[s]   = '0;
                        wait_cnt_next[s]  = '0;
                    end
                end
                default: begin
                    tick_rate_next = tick_rate_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            tick_rate_reg <= TICK_RATE_RST;
            sem_init_reg  <= SEM_INIT_RST;
            running_reg   <= '0;
            blocked_reg   <= '0;
            sleep_vld_reg <= '0;
            for (int s = 0; s < NUM_SEMS; s++) begin
                sem_value_reg[s] <= COUNT_W'(SEM_INIT_RST);
                enq_ptr_reg[s]   <= '0;
                deq_ptr_reg[s]   <= '0;
                wait_cnt_reg[s]  <= '0;
            end
            pipe_vld_reg  <= 1'b0;
            found_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            tick_rate_reg <= tick_rate_next;
            sem_init_reg  <= sem_init_next;
            running_reg   <= running_next;
            blocked_reg   <= blocked_next;
            sleep_vld_reg <= sleep_vld_next;
            sem_value_reg <= sem_value_next;
            enq_ptr_reg   <= enq_ptr_next;
            deq_ptr_reg   <= deq_ptr_next;
            wait_cnt_reg  <= wait_cnt_next;
            pipe_vld_reg  <= pipe_vld_next;
            found_reg     <= found_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg             <= op_next;
        ms_reg             <= ms_next;
        sid_reg            <= sid_next;
        tid_reg            <= tid_next;
        div_prod_reg       <= div_prod_next;
        scan_idx_reg       <= scan_idx_next;
        scan_cnt_reg       <= scan_cnt_next;
        pipe_idx_reg       <= pipe_idx_next;
        found_idx_reg      <= found_idx_next;
        res_no_ready_reg   <= res_no_ready_next;
        res_woken_vld_reg  <= res_woken_vld_next;
        res_woken_task_reg <= res_woken_task_next;
        res_count_reg      <= res_count_next;
        res_ovf_reg        <= res_ovf_next;
        m_cur_reg          <= m_cur_next;
        m_no_ready_reg     <= m_no_ready_next;
        m_woken_vld_reg    <= m_woken_vld_next;
        m_woken_task_reg   <= m_woken_task_next;
        m_count_reg        <= m_count_next;
        m_ovf_reg          <= m_ovf_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_current_task   = m_cur_reg;
    assign m_no_ready       = m_no_ready_reg;
    assign m_woken_valid    = m_woken_vld_reg;
    assign m_woken_task     = m_woken_task_reg;
    assign m_sem_count      = m_count_reg;
    assign m_queue_overflow = m_ovf_reg;

endmodule
`default_nettype wire

@@ src/tss_checker.sv @@
`default_nettype none
module tss_checker (
    input wire logic                      aclk,
    input wire logic                      aresetn,
    input wire logic                      cfg_we,
    input wire logic                      cfg_addr,
    input wire logic [tss_pkg::CFG_W-1:0] cfg_wdata,
    input wire logic                      s_valid,
    input wire logic                      s_ready,
    input wire logic [2:0]                s_operation,
    input wire logic [15:0]               s_sleep_ms,
    input wire logic [1:0]                s_sem_id,
    input wire logic [2:0]                s_task_id,
    input wire logic                      m_valid,
    input wire logic                      m_ready,
    input wire logic [2:0]                m_current_task,
    input wire logic                      m_no_ready,
    input wire logic                      m_woken_valid,
    input wire logic [2:0]                m_woken_task,
    input wire logic signed [7:0]         m_sem_count,
    input wire logic                      m_queue_overflow
);

    // one operation in flight: no transfer on the very next cycle
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while an operation is in flight");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_current_task)
            && $stable(m_sem_count) && $stable(m_woken_task))
        else $error("stalled result changed");

    // a refused P leaves a value that is not positive and schedules nothing
    a_overflow_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_queue_overflow |-> m_sem_count <= 8'sd0
            && !m_no_ready && !m_woken_valid)
        else $error("inconsistent overflow result");

    a_release_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_woken_valid |-> m_sem_count <= 8'sd0
            && !m_no_ready && !m_queue_overflow)
        else $error("inconsistent release result");

endmodule

bind task_scheduler_with_semaphores tss_checker u_tss_checker (.*);
`default_nettype wire
